// ----- src/att_pkg.sv -----
// ----------------------------------------------------------------------------
// att_pkg
// shared types, codes and sizes of the allocation tracker table
// ----------------------------------------------------------------------------
package att_pkg;

	localparam int TRACK_ENTRIES  = 64;
	localparam int POISON_ENTRIES = 32;
	localparam int ADDR_BITS      = 32;
	localparam int SIZE_BITS      = 32;
	localparam int TOTAL_BITS     = 32;
	localparam int VALUE_BITS     = 32;
	localparam int OPEN_W         = $clog2(TRACK_ENTRIES + 1);
	localparam int POISON_W       = $clog2(POISON_ENTRIES + 1);

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_QUERY = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		EV_NONE       = 2'd0,
		EV_NULL_ALLOC = 2'd1,
		EV_FULL       = 2'd2,
		EV_UNTRACKED  = 2'd3
	} ev_code_t;

	typedef enum logic [1:0] {
		LV_NONE    = 2'd0,
		LV_SUSPECT = 2'd1,
		LV_ALARM   = 2'd2
	} ev_level_t;

	typedef struct packed {
		logic                 en;
		logic [ADDR_BITS-1:0] addr;
	} cmp_t;

	typedef struct packed {
		logic                 alloc;
		logic                 drop;
		logic                 clear;
		logic [ADDR_BITS-1:0] addr;
	} commit_t;

endpackage

// ----- src/att_cell.sv -----
// ----------------------------------------------------------------------------
// att_cell
// one table entry: valid bit, address, registered match and vacancy flags,
// and the priority links to its neighbours
// ----------------------------------------------------------------------------
module att_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  att_pkg::cmp_t    cmp,
	input  att_pkg::commit_t commit,
	input  logic             vacant_below_i,
	input  logic             match_below_i,
	output logic             vacant_below_o,
	output logic             match_below_o
);

	logic                          valid_q;
	logic [att_pkg::ADDR_BITS-1:0] addr_q;
	logic                          match_q;
	logic                          vacant_q;
	logic                          take;
	logic                          hit;

	assign take           = vacant_q & ~vacant_below_i;
	assign hit            = match_q & ~match_below_i;
	assign vacant_below_o = vacant_below_i | vacant_q;
	assign match_below_o  = match_below_i | match_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			match_q  <= 1'b0;
			vacant_q <= 1'b0;
		end else begin
			if (cmp.en) begin
				match_q  <= valid_q & (addr_q == cmp.addr);
				vacant_q <= ~valid_q;
			end
			if (commit.clear) begin
				valid_q <= 1'b0;
			end else if (commit.alloc && take) begin
				valid_q <= 1'b1;
			end else if (commit.drop && hit) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit.alloc && take) begin
			addr_q <= commit.addr;
		end
	end

endmodule

// ----- src/allocation_tracker_table_unit.sv -----
// ----------------------------------------------------------------------------
// allocation_tracker_table_unit
// live allocation table built as a row of entry cells with free/match chains
// ----------------------------------------------------------------------------
// flow: one item in work at a time; s_tready stays low until its result is
//   registered. Entry compare in the accept cycle, priority chain across the
//   cells and table update when ST_EVAL is left, which waits on a stalled result
// reset: all entries invalid, counters zero, no result pending
// ----------------------------------------------------------------------------
module allocation_tracker_table_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // address, block_size
	input  logic [1:0]  s_tuser,  // operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,  // event_level, event_value, notify_task, free_allowed,
	                              // open_count, total_count, poison_count, zero pad
	output logic [1:0]  m_tuser   // event_code
);

	localparam int N = att_pkg::TRACK_ENTRIES;

	typedef enum logic {ST_IDLE, ST_EVAL} state_t;

	state_t                            state_q;
	att_pkg::op_t                      op_q;
	logic [att_pkg::ADDR_BITS-1:0]     addr_q;
	logic [att_pkg::SIZE_BITS-1:0]     size_q;
	logic [att_pkg::OPEN_W-1:0]        open_q;
	logic [att_pkg::TOTAL_BITS-1:0]    total_q;
	logic [att_pkg::POISON_W-1:0]      poison_q;

	logic [1:0]                        code_q;
	logic [1:0]                        level_q;
	logic [att_pkg::VALUE_BITS-1:0]    value_q;
	logic                              notify_q;
	logic                              allowed_q;
	logic                              out_valid_q;

	logic                              accept;
	logic                              go;
	logic                              addr_nz;
	logic                              any_vacant;
	logic                              any_match;
	logic [N:0]                        vacant_chain;
	logic [N:0]                        match_chain;
	att_pkg::cmp_t                     cmp;
	att_pkg::commit_t                  commit;

	logic [att_pkg::OPEN_W-1:0]        open_d;
	logic [att_pkg::TOTAL_BITS-1:0]    total_d;
	logic [att_pkg::POISON_W-1:0]      poison_d;
	logic [1:0]                        code_d;
	logic [1:0]                        level_d;
	logic [att_pkg::VALUE_BITS-1:0]    value_d;
	logic                              notify_d;
	logic                              allowed_d;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid & s_tready;
	assign go       = (state_q == ST_EVAL) & (~out_valid_q | m_tready);

	assign cmp.en   = accept;
	assign cmp.addr = s_tdata[att_pkg::ADDR_BITS-1:0];

	assign vacant_chain[0] = 1'b0;
	assign match_chain[0]  = 1'b0;
	assign any_vacant      = vacant_chain[N];
	assign any_match       = match_chain[N];
	assign addr_nz         = (addr_q != '0);

	assign commit.alloc = go & (op_q == att_pkg::OP_ALLOC) & addr_nz & any_vacant;
	assign commit.drop  = go & (op_q == att_pkg::OP_FREE) & addr_nz & any_match;
	assign commit.clear = go & (op_q == att_pkg::OP_CLEAR);
	assign commit.addr  = addr_q;

	for (genvar i = 0; i < N; i++) begin : g_cell
		att_cell u_cell (
			.clk            (clk),
			.arst_n         (arst_n),
			.cmp            (cmp),
			.commit         (commit),
			.vacant_below_i (vacant_chain[i]),
			.match_below_i  (match_chain[i]),
			.vacant_below_o (vacant_chain[i+1]),
			.match_below_o  (match_chain[i+1])
		);
	end

	always_comb begin
		open_d    = open_q;
		total_d   = total_q;
		poison_d  = poison_q;
		code_d    = att_pkg::EV_NONE;
		level_d   = att_pkg::LV_NONE;
		value_d   = '0;
		notify_d  = 1'b0;
		allowed_d = 1'b0;
		case (op_q)
			att_pkg::OP_ALLOC: begin
				if (!addr_nz) begin
					code_d  = att_pkg::EV_NULL_ALLOC;
					level_d = att_pkg::LV_SUSPECT;
					value_d = size_q;
				end else if (!any_vacant) begin
					code_d   = att_pkg::EV_FULL;
					level_d  = att_pkg::LV_ALARM;
					value_d  = att_pkg::VALUE_BITS'(att_pkg::TRACK_ENTRIES);
					notify_d = 1'b1;
				end else begin
					open_d  = open_q + 1'b1;
					total_d = total_q + 1'b1;
				end
			end
			att_pkg::OP_FREE: begin
				if (addr_nz) begin
					if (!any_match) begin
						code_d   = att_pkg::EV_UNTRACKED;
						level_d  = att_pkg::LV_ALARM;
						value_d  = att_pkg::VALUE_BITS'(addr_q);
						notify_d = 1'b1;
						if (poison_q != att_pkg::POISON_W'(att_pkg::POISON_ENTRIES)) begin
							poison_d = poison_q + 1'b1;
						end
					end else begin
						open_d = open_q - 1'b1;
					end
				end
			end
			att_pkg::OP_QUERY: begin
				allowed_d = addr_nz & any_match;
			end
			att_pkg::OP_CLEAR: begin
				open_d   = '0;
				total_d  = '0;
				poison_d = '0;
			end
			default: begin
				open_d = open_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			open_q      <= '0;
			total_q     <= '0;
			poison_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (go) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (go) begin
						state_q  <= ST_IDLE;
						open_q   <= open_d;
						total_q  <= total_d;
						poison_q <= poison_d;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= att_pkg::op_t'(s_tuser);
			addr_q <= s_tdata[att_pkg::ADDR_BITS-1:0];
			size_q <= s_tdata[63:32];
		end
		if (go) begin
			code_q    <= code_d;
			level_q   <= level_d;
			value_q   <= value_d;
			notify_q  <= notify_d;
			allowed_q <= allowed_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = code_q;
	assign m_tdata  = {7'd0, poison_q, total_q, open_q, allowed_q, notify_q, value_q, level_q};

endmodule

// ----- src/att_checker.sv -----
// ----------------------------------------------------------------------------
// att_checker
// port-level checks of the allocation tracker table, bound to the top level
// ----------------------------------------------------------------------------
module att_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [87:0] m_tdata,
	input logic [1:0]  m_tuser
);

	logic [1:0] level;
	logic       notify;
	logic       allowed;
	logic [6:0] open_cnt;
	logic [5:0] poison_cnt;

	assign level      = m_tdata[1:0];
	assign notify     = m_tdata[34];
	assign allowed    = m_tdata[35];
	assign open_cnt   = m_tdata[42:36];
	assign poison_cnt = m_tdata[80:75];

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("item accepted while another is in work");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	a_level: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tuser == att_pkg::EV_NONE) == (level == att_pkg::LV_NONE))
			&& (notify == ((m_tuser == att_pkg::EV_FULL)
				|| (m_tuser == att_pkg::EV_UNTRACKED))))
		else $error("event level or task flag disagrees with event code");

	a_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (open_cnt <= 7'(att_pkg::TRACK_ENTRIES))
			&& (poison_cnt <= 6'(att_pkg::POISON_ENTRIES)))
		else $error("count beyond capacity");

	a_query: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && allowed |-> m_tuser == att_pkg::EV_NONE)
		else $error("query answer with an event");

endmodule

bind allocation_tracker_table_unit att_checker u_att_checker (.*);

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// self-checking bench for allocation_tracker_table_unit
//
// Drives allocate, free, query and clear items into the stream input. A
// scoreboard keeps its own copy of the table, the counters and the poison
// pool, predicts one result per accepted item and compares every returned
// result with it, field by field, in order. A short directed sequence runs
// first. Random episodes follow, each biased towards filling the table,
// flooding the poison pool, churning live entries or plain noise. The input
// side sends in bursts with gaps and the output side stalls in changing
// patterns, and once holds off for a long stretch. The bench waits for the
// block to empty between some episodes.
// ----------------------------------------------------------------------------
module tb;

	timeunit 1ns;
	timeprecision 1ps;

	import att_pkg::*;

	localparam int CLK_PERIOD     = 10;
	localparam int RESET_CYCLES   = 7;
	localparam int IDLE_LIMIT     = 2000;
	localparam int HOLD_CYCLES    = 400;
	localparam int SETTLE_CYCLES  = 4;
	localparam int EPISODES       = 20;
	localparam int ADDR_POOL_SIZE = 40;

	typedef struct {
		ev_code_t              code;
		ev_level_t             level;
		logic [VALUE_BITS-1:0] value;
		logic                  notify;
		logic                  allowed;
		logic [OPEN_W-1:0]     open_n;
		logic [TOTAL_BITS-1:0] total_n;
		logic [POISON_W-1:0]   poison_n;
	} outcome_t;

	class tracker_scoreboard;
		logic [ADDR_BITS-1:0]  slot_addr [TRACK_ENTRIES];
		logic [SIZE_BITS-1:0]  slot_size [TRACK_ENTRIES];
		bit                    slot_live [TRACK_ENTRIES];
		logic [ADDR_BITS-1:0]  poison_addr [POISON_ENTRIES];
		logic [OPEN_W-1:0]     live_count;
		logic [TOTAL_BITS-1:0] alloc_total;
		logic [POISON_W-1:0]   poison_fill;
		outcome_t              expected_outcomes[$];
		int                    mismatches;

		function new();
			foreach (slot_live[i]) slot_live[i] = 0;
			live_count  = '0;
			alloc_total = '0;
			poison_fill = '0;
			mismatches  = 0;
		endfunction

		function int find_live(logic [ADDR_BITS-1:0] addr);
			for (int i = 0; i < TRACK_ENTRIES; i++)
				if (slot_live[i] && slot_addr[i] == addr)
					return i;
			return -1;
		endfunction

		function outcome_t predict_outcome(op_t op, logic [ADDR_BITS-1:0] addr,
				logic [SIZE_BITS-1:0] size);
			outcome_t o;
			int slot;
			o.code    = EV_NONE;
			o.level   = LV_NONE;
			o.value   = '0;
			o.notify  = 1'b0;
			o.allowed = 1'b0;
			slot      = -1;
			case (op)
				OP_ALLOC: begin
					if (addr == '0) begin
						o.code  = EV_NULL_ALLOC;
						o.level = LV_SUSPECT;
						o.value = size;
					end else begin
						for (int i = TRACK_ENTRIES - 1; i >= 0; i--)
							if (!slot_live[i]) slot = i;
						if (slot < 0) begin
							o.code   = EV_FULL;
							o.level  = LV_ALARM;
							o.value  = VALUE_BITS'(TRACK_ENTRIES);
							o.notify = 1'b1;
						end else begin
							slot_addr[slot] = addr;
							slot_size[slot] = size;
							slot_live[slot] = 1;
							live_count++;
							alloc_total++;
						end
					end
				end
				OP_FREE: begin
					if (addr != '0) begin
						slot = find_live(addr);
						if (slot < 0) begin
							o.code   = EV_UNTRACKED;
							o.level  = LV_ALARM;
							o.value  = addr;
							o.notify = 1'b1;
							if (poison_fill < POISON_ENTRIES) begin
								poison_addr[poison_fill[$clog2(POISON_ENTRIES)-1:0]] = addr;
								poison_fill++;
							end
						end else begin
							slot_live[slot] = 0;
							live_count--;
						end
					end
				end
				OP_QUERY: o.allowed = (addr != '0) && (find_live(addr) >= 0);
				default: begin
					foreach (slot_live[i]) slot_live[i] = 0;
					live_count  = '0;
					alloc_total = '0;
					poison_fill = '0;
				end
			endcase
			o.open_n   = live_count;
			o.total_n  = alloc_total;
			o.poison_n = poison_fill;
			return o;
		endfunction

		function void note_item(op_t op, logic [ADDR_BITS-1:0] addr,
				logic [SIZE_BITS-1:0] size);
			expected_outcomes.push_back(predict_outcome(op, addr, size));
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(logic [1:0] user, logic [87:0] data);
			outcome_t e;
			if (expected_outcomes.size() == 0) begin
				$display("%0t: result with nothing outstanding, expected none actual 0x%0h_%0h",
					$time, user, data);
				mismatches++;
				return;
			end
			e = expected_outcomes.pop_front();
			compare_field("event_code",   32'(e.code),     32'(user));
			compare_field("event_level",  32'(e.level),    32'(data[1:0]));
			compare_field("event_value",  e.value,         data[33:2]);
			compare_field("notify_task",  32'(e.notify),   32'(data[34]));
			compare_field("free_allowed", 32'(e.allowed),  32'(data[35]));
			compare_field("open_count",   32'(e.open_n),   32'(data[42:36]));
			compare_field("total_count",  e.total_n,       data[74:43]);
			compare_field("poison_count", 32'(e.poison_n), 32'(data[80:75]));
		endfunction

		function int pending();
			return expected_outcomes.size();
		endfunction

		function logic [ADDR_BITS-1:0] pick_tracked();
			int live_idx[$];
			for (int i = 0; i < TRACK_ENTRIES; i++)
				if (slot_live[i]) live_idx.push_back(i);
			if (live_idx.size() == 0)
				return $urandom;
			return slot_addr[live_idx[$urandom_range(0, live_idx.size() - 1)]];
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;   // address, block_size
	logic [1:0]  s_tuser;   // operation
	logic        m_tvalid;
	logic        m_tready;
	logic [87:0] m_tdata;   // event_level, event_value, notify_task, free_allowed,
	                        // open_count, total_count, poison_count, zero pad
	logic [1:0]  m_tuser;   // event_code

	tracker_scoreboard    board;
	logic [ADDR_BITS-1:0] addr_pool [ADDR_POOL_SIZE];
	int                   burst_left;
	int                   idle_cycles;
	bit                   hold_req;
	int                   hold_left;
	int                   rx_mode;
	int                   rx_mode_left;
	int                   rx_phase;

	allocation_tracker_table_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// output side stall patterns, plus one long hold-off on request
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req  = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			if (rx_mode_left == 0) begin
				rx_mode      = $urandom_range(0, 3);
				rx_mode_left = $urandom_range(16, 96);
			end
			rx_mode_left--;
			rx_phase++;
			case (rx_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= (rx_phase % 5 != 0);
			endcase
		end
	end

	// handshake monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				board.check_result(m_tuser, m_tdata);
			if (s_tvalid && s_tready)
				board.note_item(op_t'(s_tuser), s_tdata[31:0], s_tdata[63:32]);
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	task automatic send_item(op_t op, logic [ADDR_BITS-1:0] addr, logic [SIZE_BITS-1:0] size);
		int gap;
		if (burst_left == 0) begin
			gap        = $urandom_range(0, 8);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {size, addr};
		do @(posedge clk); while (!s_tready);
		burst_left--;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_tvalid  <= 1'b0;
		burst_left = 0;
		while (board.pending() > 0) @(negedge clk);
	endtask

	function automatic logic [ADDR_BITS-1:0] pick_addr();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return '0;
		if (r < 75)
			return addr_pool[$urandom_range(0, ADDR_POOL_SIZE - 1)];
		return $urandom;
	endfunction

	initial begin
		int   kind;
		int   len;
		int   r;
		op_t  op;
		logic [ADDR_BITS-1:0] addr;

		clk          = 1'b0;
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = OP_ALLOC;
		m_tready     = 1'b0;
		burst_left   = 0;
		idle_cycles  = 0;
		hold_req     = 0;
		hold_left    = 0;
		rx_mode      = 0;
		rx_mode_left = 0;
		rx_phase     = 0;
		board        = new();
		foreach (addr_pool[i]) addr_pool[i] = $urandom;
		addr_pool[0] = 32'hFFFF_FFFF;
		addr_pool[1] = 32'h0000_0001;
		addr_pool[2] = 32'h8000_0000;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: null allocation, duplicates, queries, null and untracked free, clear
		send_item(OP_ALLOC, 32'h0000_0000, 32'hFFFF_FFFF);
		send_item(OP_ALLOC, 32'h0000_0000, 32'h0000_0000);
		send_item(OP_ALLOC, 32'hFFFF_FFFF, 32'h0000_0000);
		send_item(OP_ALLOC, 32'h0000_0001, 32'hFFFF_FFFF);
		send_item(OP_ALLOC, 32'h1234_5678, 32'h0000_0100);
		send_item(OP_ALLOC, 32'h1234_5678, 32'h0000_0200);
		send_item(OP_QUERY, 32'h1234_5678, 32'h0000_0000);
		send_item(OP_QUERY, 32'h0000_0000, 32'hFFFF_FFFF);
		send_item(OP_QUERY, 32'hDEAD_BEEF, 32'h0000_0000);
		send_item(OP_FREE,  32'h1234_5678, 32'h0000_0000);
		send_item(OP_QUERY, 32'h1234_5678, 32'h0000_0000);
		send_item(OP_FREE,  32'h1234_5678, 32'h0000_0000);
		send_item(OP_QUERY, 32'h1234_5678, 32'h0000_0000);
		send_item(OP_FREE,  32'h0000_0000, 32'h0000_0000);
		send_item(OP_FREE,  32'hDEAD_BEEF, 32'hFFFF_FFFF);
		send_item(OP_FREE,  32'hFFFF_FFFF, 32'h0000_0000);
		send_item(OP_ALLOC, 32'h8000_0000, 32'h5555_AAAA);
		send_item(OP_FREE,  32'h8000_0000, 32'hAAAA_5555);
		send_item(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(OP_QUERY, 32'h0000_0001, 32'h0000_0000);
		send_item(OP_CLEAR, 32'h0000_0000, 32'h0000_0000);
		wait_drained();

		// random episodes: fill the table, flood the poison pool, churn, noise
		for (int ep = 0; ep < EPISODES; ep++) begin
			kind = ep % 4;
			if (ep == 2)
				hold_req = 1;
			if ($urandom_range(0, 3) != 0)
				send_item(OP_CLEAR, $urandom, $urandom);
			len = (kind == 0) ? 110 : (kind == 1) ? 80 : 100;
			for (int n = 0; n < len; n++) begin
				r = $urandom_range(0, 99);
				case (kind)
					0: begin
						op   = (r < 85) ? OP_ALLOC : (r < 93) ? OP_FREE : OP_QUERY;
						addr = (op == OP_ALLOC) ? pick_addr() : board.pick_tracked();
					end
					1: begin
						op   = (r < 65) ? OP_FREE : (r < 80) ? OP_ALLOC :
							(r < 90) ? OP_FREE : OP_QUERY;
						addr = (r < 65) ? $urandom :
							(op == OP_ALLOC) ? pick_addr() : board.pick_tracked();
					end
					2: begin
						op   = (r < 40) ? OP_ALLOC : (r < 75) ? OP_FREE :
							(r < 95) ? OP_QUERY : op_t'($urandom_range(0, 1));
						addr = (r >= 95) ? '0 :
							(op == OP_ALLOC) ? pick_addr() :
							(r < 85) ? board.pick_tracked() : pick_addr();
					end
					default: begin
						op   = (r < 3) ? OP_CLEAR : op_t'($urandom_range(0, 2));
						addr = (r < 40) ? board.pick_tracked() : pick_addr();
					end
				endcase
				send_item(op, addr, $urandom);
			end
			if (ep % 3 == 2)
				wait_drained();
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (board.mismatches == 0 && board.pending() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
src/att_pkg.sv
src/att_cell.sv
src/allocation_tracker_table_unit.sv
src/att_checker.sv
tb/sv/tb.sv
